// ----- hw/rtl/wwlm_pkg.sv -----
// wwlm_pkg: shared types and codes for the wound-wait lock manager
package wwlm_pkg;

    localparam int CMD_W = 2;
    localparam int ID_W  = 4;
    localparam int VAR_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_BEGIN,
        CMD_READ,
        CMD_WRITE,
        CMD_COMMIT
    } cmd_t;

    typedef enum logic [2:0] {
        EV_STARTED,
        EV_ACQUIRED,
        EV_HELD,
        EV_QUEUED,
        EV_WOUND,
        EV_COMPLETED,
        EV_WOKEN,
        EV_IGNORED
    } ev_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOK,
        S_CMP,
        S_FREE_RD,
        S_FREE_CHK,
        S_END,
        S_DROP_RD,
        S_DROP_CHK,
        S_WAKE_RD,
        S_WAKE_PV,
        S_WAKE_CHK,
        S_FLUSH
    } state_t;

    typedef struct packed {
        cmd_t             command;
        logic [ID_W-1:0]  txn_id;
        logic [VAR_W-1:0] var_index;
    } req_t;

    typedef struct packed {
        ev_t              event_res;
        logic [ID_W-1:0]  subject_id;
        logic [ID_W-1:0]  victim_id;
        logic [VAR_W-1:0] granted_var;
        logic             last;
    } rsp_t;

    typedef struct packed {
        ev_t              event_res;
        logic [ID_W-1:0]  subject_id;
        logic [ID_W-1:0]  victim_id;
        logic [VAR_W-1:0] granted_var;
    } evt_body_t;

    typedef struct packed {
        logic      load;
        logic      flush;
        evt_body_t body;
    } buf_ctl_t;

    typedef struct packed {
        logic slot_free;
        logic hold_vld;
    } buf_sts_t;

endpackage

// ----- hw/rtl/wwlm_if.sv -----
// wwlm_if: valid/ready channel interfaces for commands and events
interface wwlm_req_if;
    logic          valid;
    logic          ready;
    wwlm_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wwlm_rsp_if;
    logic          valid;
    logic          ready;
    wwlm_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/wwlm_evt_buf.sv -----
// wwlm_evt_buf: one-event hold stage plus output register, marks the last beat
module wwlm_evt_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  wwlm_pkg::buf_ctl_t ctl,
    output wwlm_pkg::buf_sts_t sts,
    wwlm_rsp_if.source         rsp
);

    wwlm_pkg::evt_body_t hold_reg, hold_next;
    logic                hold_vld_reg, hold_vld_next;
    wwlm_pkg::rsp_t      out_reg, out_next;
    logic                out_vld_reg, out_vld_next;

    assign sts.slot_free = !out_vld_reg || rsp.ready;
    assign sts.hold_vld  = hold_vld_reg;
    assign rsp.valid     = out_vld_reg;
    assign rsp.data      = out_reg;

    always_comb
    begin
        hold_next     = hold_reg;
        hold_vld_next = hold_vld_reg;
        out_next      = out_reg;
        out_vld_next  = out_vld_reg && !rsp.ready;
        if (ctl.load)
        begin
            // older held event goes out, it is not the final one
            if (hold_vld_reg)
            begin
                out_vld_next         = 1'b1;
                out_next.event_res   = hold_reg.event_res;
                out_next.subject_id  = hold_reg.subject_id;
                out_next.victim_id   = hold_reg.victim_id;
                out_next.granted_var = hold_reg.granted_var;
                out_next.last        = 1'b0;
            end
            hold_next     = ctl.body;
            hold_vld_next = 1'b1;
        end
        if (ctl.flush)
        begin
            out_vld_next         = 1'b1;
            out_next.event_res   = hold_reg.event_res;
            out_next.subject_id  = hold_reg.subject_id;
            out_next.victim_id   = hold_reg.victim_id;
            out_next.granted_var = hold_reg.granted_var;
            out_next.last        = 1'b1;
            hold_vld_next        = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            hold_vld_reg <= hold_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

    a_flush_has_event: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.flush |-> (hold_vld_reg && (!out_vld_reg || rsp.ready)))
        else $error("flush without a held event or free output slot");

    a_load_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.load && hold_vld_reg) |-> (!out_vld_reg || rsp.ready))
        else $error("event pushed over an untaken output beat");

    a_no_load_flush: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.load && ctl.flush))
        else $error("load and flush in the same cycle");

endmodule

// ----- hw/rtl/wound_wait_lock_manager.sv -----
// wound_wait_lock_manager: wound-wait exclusive lock manager, top level
//
//  channel  dir  beat payload                                   handshake
//  req      in   command, txn_id, var_index                     valid/ready
//  rsp      out  event_res, subject_id, victim_id, granted_var,  valid/ready
//                last
//
// one command at a time; begin, lock and ignored commands step through accept,
// look and flush, and a contended lock adds a stamp compare before the flush
// commit and wound sweep the lock table with a read and a check per variable,
// pass an end state, drop a waiting target from the queue with a read and check per
// waiter, then run the wake scan (read, pending variable, check), on single read ports
// reset clears lock valid flops, flags and queue count at once, no clearing pass
// a stalled rsp holds the engine only when a new event meets a full output register
module wound_wait_lock_manager #(
    parameter int NUM_VARS    = 26,
    parameter int NUM_TXNS    = 16,
    parameter int STAMP_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    wwlm_req_if.sink   req,
    wwlm_rsp_if.source rsp
);

    localparam int TXN_W = $clog2(NUM_TXNS);
    localparam int VIX_W = $clog2(NUM_VARS);
    localparam int CNT_W = $clog2(NUM_TXNS + 1);
    localparam int TM_W  = STAMP_WIDTH + VIX_W;

    // control and item registers
    wwlm_pkg::state_t        state_reg, state_next;
    wwlm_pkg::cmd_t          cmd_reg, cmd_next;
    logic [wwlm_pkg::ID_W-1:0]  id_reg, id_next;
    logic [wwlm_pkg::VAR_W-1:0] var_reg, var_next;
    logic [STAMP_WIDTH-1:0]  stamp_cnt_reg, stamp_cnt_next;
    logic [STAMP_WIDTH-1:0]  rs_reg, rs_next;
    logic [TXN_W-1:0]        victim_reg, victim_next;
    logic [TXN_W-1:0]        tgt_reg, tgt_next;
    logic [TXN_W-1:0]        wt_reg, wt_next;
    logic [VIX_W-1:0]        vsw_reg, vsw_next;
    logic [CNT_W-1:0]        i_reg, i_next;
    logic [CNT_W-1:0]        j_reg, j_next;
    logic [CNT_W-1:0]        wcount_reg, wcount_next;
    logic [NUM_TXNS-1:0]     active_reg, active_next;
    logic [NUM_TXNS-1:0]     waiting_reg, waiting_next;
    logic [NUM_VARS-1:0]     lock_vld_reg, lock_vld_next;

    // lock owner table
    logic [TXN_W-1:0] owner_mem [NUM_VARS];
    logic [TXN_W-1:0] owner_q;
    logic [VIX_W-1:0] owner_raddr, owner_waddr;
    logic [TXN_W-1:0] owner_wdata;
    logic             owner_we;

    // per transaction {stamp, pending variable}
    logic [TM_W-1:0]  txn_mem [NUM_TXNS];
    logic [TM_W-1:0]  txn_q;
    logic [TXN_W-1:0] txn_raddr, txn_waddr;
    logic [TM_W-1:0]  txn_wdata;
    logic             txn_we;

    // wait queue, compacted in place
    logic [TXN_W-1:0] fifo_mem [NUM_TXNS];
    logic [TXN_W-1:0] fifo_q;
    logic [TXN_W-1:0] fifo_raddr, fifo_waddr;
    logic [TXN_W-1:0] fifo_wdata;
    logic             fifo_we;

    wwlm_pkg::buf_ctl_t ctl;
    wwlm_pkg::buf_sts_t sts;

    logic             accept;
    logic [TXN_W-1:0] tix;
    logic [VIX_W-1:0] vix;
    logic             id_ok, var_ok;
    wwlm_pkg::ev_t    look_ev, cmp_ev;
    logic             look_contend;
    logic [STAMP_WIDTH-1:0] q_stamp;
    logic [VIX_W-1:0] pv;
    logic             wake_grant;

    assign accept  = req.valid && req.ready;
    assign tix     = TXN_W'(id_reg);
    assign vix     = VIX_W'(var_reg);
    assign id_ok   = 32'(id_reg) < NUM_TXNS;
    assign var_ok  = 32'(var_reg) < NUM_VARS;
    assign q_stamp = txn_q[TM_W-1:VIX_W];
    assign pv      = txn_q[VIX_W-1:0];
    assign wake_grant = !lock_vld_reg[pv];

    // decision once the owner and requester stamp are read
    always_comb
    begin
        look_ev      = wwlm_pkg::EV_IGNORED;
        look_contend = 1'b0;
        if (id_ok)
        begin
            case (cmd_reg)
                wwlm_pkg::CMD_BEGIN:
                    look_ev = active_reg[tix] ? wwlm_pkg::EV_IGNORED : wwlm_pkg::EV_STARTED;
                wwlm_pkg::CMD_COMMIT:
                    look_ev = active_reg[tix] ? wwlm_pkg::EV_COMPLETED : wwlm_pkg::EV_IGNORED;
                wwlm_pkg::CMD_READ, wwlm_pkg::CMD_WRITE:
                begin
                    if (!active_reg[tix] || waiting_reg[tix] || !var_ok)
                        look_ev = wwlm_pkg::EV_IGNORED;
                    else if (!lock_vld_reg[vix])
                        look_ev = wwlm_pkg::EV_ACQUIRED;
                    else if (owner_q == tix)
                        look_ev = wwlm_pkg::EV_HELD;
                    else
                        look_contend = 1'b1;
                end
                default:
                    look_ev = wwlm_pkg::EV_IGNORED;
            endcase
        end
    end

    // younger requester waits, older one wounds, equal stamps do nothing
    always_comb
    begin
        if (rs_reg > q_stamp)
            cmp_ev = wwlm_pkg::EV_QUEUED;
        else if (rs_reg < q_stamp)
            cmp_ev = wwlm_pkg::EV_WOUND;
        else
            cmp_ev = wwlm_pkg::EV_IGNORED;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wwlm_pkg::S_IDLE:
                if (accept)
                    state_next = wwlm_pkg::S_LOOK;
            wwlm_pkg::S_LOOK:
                if (look_contend)
                    state_next = wwlm_pkg::S_CMP;
                else if (look_ev == wwlm_pkg::EV_COMPLETED)
                    state_next = wwlm_pkg::S_FREE_RD;
                else
                    state_next = wwlm_pkg::S_FLUSH;
            wwlm_pkg::S_CMP:
                state_next = (cmp_ev == wwlm_pkg::EV_WOUND) ? wwlm_pkg::S_FREE_RD
                                                            : wwlm_pkg::S_FLUSH;
            wwlm_pkg::S_FREE_RD:
                state_next = wwlm_pkg::S_FREE_CHK;
            wwlm_pkg::S_FREE_CHK:
                state_next = (vsw_reg == VIX_W'(NUM_VARS - 1)) ? wwlm_pkg::S_END
                                                               : wwlm_pkg::S_FREE_RD;
            wwlm_pkg::S_END:
                state_next = waiting_reg[tgt_reg] ? wwlm_pkg::S_DROP_RD : wwlm_pkg::S_WAKE_RD;
            wwlm_pkg::S_DROP_RD:
                state_next = (i_reg == wcount_reg) ? wwlm_pkg::S_WAKE_RD : wwlm_pkg::S_DROP_CHK;
            wwlm_pkg::S_DROP_CHK:
                state_next = wwlm_pkg::S_DROP_RD;
            wwlm_pkg::S_WAKE_RD:
                state_next = (i_reg == wcount_reg) ? wwlm_pkg::S_FLUSH : wwlm_pkg::S_WAKE_PV;
            wwlm_pkg::S_WAKE_PV:
                state_next = wwlm_pkg::S_WAKE_CHK;
            wwlm_pkg::S_WAKE_CHK:
                if (!wake_grant || sts.slot_free)
                    state_next = wwlm_pkg::S_WAKE_RD;
            wwlm_pkg::S_FLUSH:
                if (sts.slot_free)
                    state_next = wwlm_pkg::S_IDLE;
            default:
                state_next = wwlm_pkg::S_IDLE;
        endcase
    end

    // datapath, memory ports and event buffer control
    always_comb
    begin
        cmd_next       = cmd_reg;
        id_next        = id_reg;
        var_next       = var_reg;
        stamp_cnt_next = stamp_cnt_reg;
        rs_next        = rs_reg;
        victim_next    = victim_reg;
        tgt_next       = tgt_reg;
        wt_next        = wt_reg;
        vsw_next       = vsw_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        wcount_next    = wcount_reg;
        active_next    = active_reg;
        waiting_next   = waiting_reg;
        lock_vld_next  = lock_vld_reg;

        owner_raddr = '0;
        owner_we    = 1'b0;
        owner_waddr = vix;
        owner_wdata = tix;
        txn_raddr   = '0;
        txn_we      = 1'b0;
        txn_waddr   = tix;
        txn_wdata   = '0;
        fifo_raddr  = i_reg[TXN_W-1:0];
        fifo_we     = 1'b0;
        fifo_waddr  = j_reg[TXN_W-1:0];
        fifo_wdata  = '0;

        ctl.load  = 1'b0;
        ctl.flush = 1'b0;
        ctl.body.event_res   = look_ev;
        ctl.body.subject_id  = id_reg;
        ctl.body.victim_id   = '0;
        ctl.body.granted_var = '0;

        req.ready = (state_reg == wwlm_pkg::S_IDLE);

        case (state_reg)
            wwlm_pkg::S_IDLE:
            begin
                owner_raddr = VIX_W'(req.data.var_index);
                txn_raddr   = TXN_W'(req.data.txn_id);
                if (accept)
                begin
                    cmd_next = req.data.command;
                    id_next  = req.data.txn_id;
                    var_next = req.data.var_index;
                    // saturating item counter
                    if (stamp_cnt_reg != '1)
                        stamp_cnt_next = stamp_cnt_reg + 1'b1;
                end
            end
            wwlm_pkg::S_LOOK:
            begin
                // holder stamp is fetched while the outcome is settled
                txn_raddr   = owner_q;
                rs_next     = q_stamp;
                victim_next = owner_q;
                if (!look_contend)
                begin
                    ctl.load = 1'b1;
                    if (look_ev == wwlm_pkg::EV_ACQUIRED || look_ev == wwlm_pkg::EV_HELD)
                        ctl.body.granted_var = var_reg;
                    case (look_ev)
                        wwlm_pkg::EV_STARTED:
                        begin
                            active_next[tix]  = 1'b1;
                            waiting_next[tix] = 1'b0;
                            txn_we    = 1'b1;
                            txn_wdata = {stamp_cnt_reg, {VIX_W{1'b0}}};
                        end
                        wwlm_pkg::EV_ACQUIRED:
                        begin
                            lock_vld_next[vix] = 1'b1;
                            owner_we = 1'b1;
                        end
                        wwlm_pkg::EV_COMPLETED:
                        begin
                            tgt_next = tix;
                            vsw_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            wwlm_pkg::S_CMP:
            begin
                ctl.load = 1'b1;
                ctl.body.event_res = cmp_ev;
                case (cmp_ev)
                    wwlm_pkg::EV_QUEUED:
                    begin
                        ctl.body.granted_var = var_reg;
                        waiting_next[tix] = 1'b1;
                        txn_we    = 1'b1;
                        txn_wdata = {rs_reg, vix};
                        if (32'(wcount_reg) < NUM_TXNS)
                        begin
                            fifo_we     = 1'b1;
                            fifo_waddr  = wcount_reg[TXN_W-1:0];
                            fifo_wdata  = tix;
                            wcount_next = wcount_reg + 1'b1;
                        end
                    end
                    wwlm_pkg::EV_WOUND:
                    begin
                        ctl.body.granted_var = var_reg;
                        ctl.body.victim_id   = wwlm_pkg::ID_W'(victim_reg);
                        // lock changes hands now; sweep skips it since owner differs
                        owner_we = 1'b1;
                        tgt_next = victim_reg;
                        vsw_next = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            wwlm_pkg::S_FREE_RD:
                owner_raddr = vsw_reg;
            wwlm_pkg::S_FREE_CHK:
            begin
                if (lock_vld_reg[vsw_reg] && owner_q == tgt_reg)
                    lock_vld_next[vsw_reg] = 1'b0;
                vsw_next = vsw_reg + 1'b1;
            end
            wwlm_pkg::S_END:
            begin
                active_next[tgt_reg]  = 1'b0;
                waiting_next[tgt_reg] = 1'b0;
                i_next = '0;
                j_next = '0;
            end
            wwlm_pkg::S_DROP_RD:
                if (i_reg == wcount_reg)
                begin
                    wcount_next = j_reg;
                    i_next = '0;
                    j_next = '0;
                end
            wwlm_pkg::S_DROP_CHK:
            begin
                if (fifo_q != tgt_reg)
                begin
                    fifo_we    = 1'b1;
                    fifo_wdata = fifo_q;
                    j_next     = j_reg + 1'b1;
                end
                i_next = i_reg + 1'b1;
            end
            wwlm_pkg::S_WAKE_RD:
                if (i_reg == wcount_reg)
                    wcount_next = j_reg;
            wwlm_pkg::S_WAKE_PV:
            begin
                txn_raddr = fifo_q;
                wt_next   = fifo_q;
            end
            wwlm_pkg::S_WAKE_CHK:
            begin
                // keep the pending variable on the read port while stalled
                txn_raddr = wt_reg;
                if (wake_grant)
                begin
                    if (sts.slot_free)
                    begin
                        lock_vld_next[pv]    = 1'b1;
                        owner_we             = 1'b1;
                        owner_waddr          = pv;
                        owner_wdata          = wt_reg;
                        waiting_next[wt_reg] = 1'b0;
                        ctl.load             = 1'b1;
                        ctl.body.event_res   = wwlm_pkg::EV_WOKEN;
                        ctl.body.subject_id  = wwlm_pkg::ID_W'(wt_reg);
                        ctl.body.granted_var = wwlm_pkg::VAR_W'(pv);
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    fifo_we    = 1'b1;
                    fifo_wdata = wt_reg;
                    j_next     = j_reg + 1'b1;
                    i_next     = i_reg + 1'b1;
                end
            end
            wwlm_pkg::S_FLUSH:
                ctl.flush = sts.slot_free;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wwlm_pkg::S_IDLE;
            stamp_cnt_reg <= '0;
            wcount_reg    <= '0;
            active_reg    <= '0;
            waiting_reg   <= '0;
            lock_vld_reg  <= '0;
            vsw_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            stamp_cnt_reg <= stamp_cnt_next;
            wcount_reg    <= wcount_next;
            active_reg    <= active_next;
            waiting_reg   <= waiting_next;
            lock_vld_reg  <= lock_vld_next;
            vsw_reg       <= vsw_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        id_reg     <= id_next;
        var_reg    <= var_next;
        rs_reg     <= rs_next;
        victim_reg <= victim_next;
        tgt_reg    <= tgt_next;
        wt_reg     <= wt_next;
    end

    // memories, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (owner_we)
            owner_mem[owner_waddr] <= owner_wdata;
        owner_q <= owner_mem[owner_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (txn_we)
            txn_mem[txn_waddr] <= txn_wdata;
        txn_q <= txn_mem[txn_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (fifo_we)
            fifo_mem[fifo_waddr] <= fifo_wdata;
        fifo_q <= fifo_mem[fifo_raddr];
    end

    wwlm_evt_buf u_evt_buf (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .sts   (sts),
        .rsp   (rsp)
    );

    a_wait_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
        (waiting_reg & ~active_reg) == '0)
        else $error("waiting transaction is not active");

    a_queue_matches_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wwlm_pkg::S_IDLE) |-> ($countones(waiting_reg) == 32'(wcount_reg)))
        else $error("wait queue depth differs from waiting flags");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(wcount_reg) <= NUM_TXNS)
        else $error("wait queue overflow");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("second command taken while one is in work");

endmodule
